/* sv/amcd_pkg.sv */
// Package for the ASCII motion command decoder: result kinds, error codes,
// scanner state encoding and the byte constants the line parser compares against.
// No dependencies.
package amcd_pkg;

   localparam int KIND_W = 3;
   localparam int ERR_W  = 3;

   localparam logic [KIND_W-1:0] KIND_STATUS    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ARM       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STOP_AXIS = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISARM    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd6;

   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_FORMAT   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_AXIS     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd4;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Keyword candidates, one bit each, tracked while the line is scanned.
   localparam int NUM_KW = 8;
   localparam int KW_PING   = 0;
   localparam int KW_STATUS = 1;
   localparam int KW_ARM    = 2;
   localparam int KW_HBSAFE = 3;
   localparam int KW_HBUNS  = 4;
   localparam int KW_DISARM = 5;
   localparam int KW_STOP   = 6;   // "STOP" exact, and "STOP " prefix
   localparam int KW_MOVE   = 7;   // "MOVE " prefix

   localparam int KW_LEN_MAX = 16;

   // Keyword character at position i, or 0 past its end.
   function automatic logic [7:0] kw_char(input int kw, input logic [3:0] i);
      string s;
      logic [7:0] c;
      begin
         unique case (kw)
            KW_PING:   s = "PING";
            KW_STATUS: s = "STATUS";
            KW_ARM:    s = "ARM SAFE";
            KW_HBSAFE: s = "HEARTBEAT SAFE";
            KW_HBUNS:  s = "HEARTBEAT UNSAFE";
            KW_DISARM: s = "DISARM";
            KW_STOP:   s = "STOP ";
            KW_MOVE:   s = "MOVE ";
            default:   s = "";
         endcase
         c = 8'h00;
         if (int'(i) < s.len()) begin
            c = s[int'(i)];
         end
         kw_char = c;
      end
   endfunction

   function automatic logic [4:0] kw_len(input int kw);
      unique case (kw)
         KW_PING:   kw_len = 5'd4;
         KW_STATUS: kw_len = 5'd6;
         KW_ARM:    kw_len = 5'd8;
         KW_HBSAFE: kw_len = 5'd14;
         KW_HBUNS:  kw_len = 5'd16;
         KW_DISARM: kw_len = 5'd6;
         KW_STOP:   kw_len = 5'd5;
         KW_MOVE:   kw_len = 5'd5;
         default:   kw_len = 5'd0;
      endcase
   endfunction

   // Move parser phases after "MOVE ".
   typedef enum logic [2:0] {
      MV_AXIS,
      MV_DIR,
      MV_STEPS0,
      MV_STEPS,
      MV_SPEED0,
      MV_SPEED,
      MV_TAIL,
      MV_FAIL
   } move_phase_type;

   // Top-level sequencer states.
   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_SCAN,
      ST_FINISH,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ERR_W-1:0]  error_code;
      logic [1:0]        axis_index;
      logic              move_direction;
      logic [31:0]       step_count;
      logic [31:0]       step_speed;
   } result_type;

endpackage

/* sv/amcd_line_ram.sv */
// Line store for the command decoder: one write port, one registered read port.
// Depends on nothing; sized by the top level.
module amcd_line_ram #(
   parameter int DEPTH  = 95,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write held characters, read one per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/amcd_parser.sv */
// Character-serial line parser: consumes one stored character per cycle while
// char_en is high and classifies the line. Depends on amcd_pkg.
module amcd_parser #(
   parameter int LEN_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,     // clear for a new line
   input  logic                 char_en,   // chr is the character at pos
   input  logic [LEN_W-1:0]     pos,
   input  logic [7:0]           chr,
   input  logic [LEN_W-1:0]     line_len,
   output amcd_pkg::result_type result
);
   import amcd_pkg::*;

   logic [NUM_KW-1:0] kw_ok_ff, kw_ok_in;
   move_phase_type    ph_ff, ph_in;
   logic [1:0]        axis_ff, axis_in;
   logic              dir_ff, dir_in;
   logic [31:0]       steps_ff, steps_in, speed_ff, speed_in;
   logic              axis_bad_ff, axis_bad_in;
   logic [7:0]        ch5_ff, ch5_in;
   logic              is_dig, is_sp, mv_active;
   logic [31:0]       digit;

   assign is_dig = (chr >= CH_ZERO) && (chr <= CH_NINE);
   assign is_sp  = (chr == CH_SPACE);
   assign digit  = {28'd0, chr[3:0]};
   assign mv_active = (pos >= LEN_W'(5));

   // Track keyword matches and run the move token machine.
   always_comb begin
      kw_ok_in    = kw_ok_ff;
      ph_in       = ph_ff;
      axis_in     = axis_ff;
      dir_in      = dir_ff;
      steps_in    = steps_ff;
      speed_in    = speed_ff;
      axis_bad_in = axis_bad_ff;
      ch5_in      = ch5_ff;
      if (start) begin
         kw_ok_in    = '1;
         ph_in       = MV_AXIS;
         axis_in     = 2'd0;
         dir_in      = 1'b0;
         steps_in    = 32'd0;
         speed_in    = 32'd0;
         axis_bad_in = 1'b0;
         ch5_in      = 8'h00;
      end else if (char_en) begin
         for (int k = 0; k < NUM_KW; k++) begin
            if (pos < LEN_W'(KW_LEN_MAX) && kw_char(k, pos[3:0]) != 8'h00 &&
                chr != kw_char(k, pos[3:0])) begin
               kw_ok_in[k] = 1'b0;
            end
         end
         if (pos == LEN_W'(5)) begin
            ch5_in = chr;
         end
         if (mv_active) begin
            unique case (ph_ff)
               MV_AXIS: begin
                  if (!is_sp) begin
                     ph_in = MV_DIR;
                     if (chr == "X" || chr == "x") axis_in = 2'd0;
                     else if (chr == "Y" || chr == "y") axis_in = 2'd1;
                     else if (chr == "Z" || chr == "z") axis_in = 2'd2;
                     else begin
                        axis_bad_in = 1'b1;
                        ph_in = MV_FAIL;
                     end
                  end
               end
               MV_DIR: begin
                  if (!is_sp) begin
                     if (chr == "0" || chr == "1") begin
                        dir_in = chr[0];
                        ph_in  = MV_STEPS0;
                     end else begin
                        ph_in = MV_FAIL;
                     end
                  end
               end
               MV_STEPS0, MV_STEPS: begin
                  if (is_dig) begin
                     steps_in = (steps_ff << 3) + (steps_ff << 1) + digit;
                     ph_in = MV_STEPS;
                  end else if (is_sp) begin
                     ph_in = (ph_ff == MV_STEPS) ? MV_SPEED0 : MV_STEPS0;
                  end else begin
                     ph_in = MV_FAIL;
                  end
               end
               MV_SPEED0, MV_SPEED: begin
                  if (is_dig) begin
                     speed_in = (speed_ff << 3) + (speed_ff << 1) + digit;
                     ph_in = MV_SPEED;
                  end else if (is_sp) begin
                     ph_in = (ph_ff == MV_SPEED) ? MV_TAIL : MV_SPEED0;
                  end else begin
                     ph_in = MV_FAIL;
                  end
               end
               MV_TAIL: begin
                  if (!is_sp) ph_in = MV_FAIL;
               end
               MV_FAIL: ph_in = MV_FAIL;
               default: ph_in = MV_FAIL;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ok_ff <= '1;
         ph_ff    <= MV_AXIS;
      end else begin
         kw_ok_ff <= kw_ok_in;
         ph_ff    <= ph_in;
      end
      axis_ff     <= axis_in;
      dir_ff      <= dir_in;
      steps_ff    <= steps_in;
      speed_ff    <= speed_in;
      axis_bad_ff <= axis_bad_in;
      ch5_ff      <= ch5_in;
   end

   function automatic logic exact(input logic ok, input logic [4:0] n,
                                  input logic [LEN_W-1:0] len);
      exact = ok && ({{(LEN_W > 5 ? LEN_W - 5 : 0){1'b0}}, n} == len);
   endfunction

   // Classify the scanned line.
   always_comb begin
      logic pre_stop, pre_move;
      pre_stop = kw_ok_ff[KW_STOP] && (line_len >= LEN_W'(5));
      pre_move = kw_ok_ff[KW_MOVE] && (line_len >= LEN_W'(5));
      result = '0;
      priority if (exact(kw_ok_ff[KW_PING], kw_len(KW_PING), line_len) ||
                   exact(kw_ok_ff[KW_STATUS], kw_len(KW_STATUS), line_len)) begin
         result.kind = KIND_STATUS;
      end else if (exact(kw_ok_ff[KW_ARM], kw_len(KW_ARM), line_len)) begin
         result.kind = KIND_ARM;
      end else if (exact(kw_ok_ff[KW_HBSAFE], kw_len(KW_HBSAFE), line_len)) begin
         result.kind = KIND_HEARTBEAT;
      end else if (pre_stop && line_len == LEN_W'(6)) begin
         if (ch5_ff == "X") begin
            result.kind = KIND_STOP_AXIS; result.axis_index = 2'd0;
         end else if (ch5_ff == "Y") begin
            result.kind = KIND_STOP_AXIS; result.axis_index = 2'd1;
         end else if (ch5_ff == "Z") begin
            result.kind = KIND_STOP_AXIS; result.axis_index = 2'd2;
         end else begin
            result.kind = KIND_ERROR; result.error_code = ERR_AXIS;
         end
      end else if (exact(kw_ok_ff[KW_HBUNS], kw_len(KW_HBUNS), line_len) ||
                   (kw_ok_ff[KW_STOP] && line_len == LEN_W'(4)) ||
                   exact(kw_ok_ff[KW_DISARM], kw_len(KW_DISARM), line_len)) begin
         result.kind = KIND_DISARM;
      end else if (pre_move) begin
         if (axis_bad_ff) begin
            result.kind = KIND_ERROR; result.error_code = ERR_AXIS;
         end else if (ph_ff == MV_SPEED || ph_ff == MV_TAIL) begin
            result.kind           = KIND_MOVE;
            result.axis_index     = axis_ff;
            result.move_direction = dir_ff;
            result.step_count     = steps_ff;
            result.step_speed     = speed_ff;
         end else begin
            result.kind = KIND_ERROR; result.error_code = ERR_FORMAT;
         end
      end else begin
         result.kind = KIND_ERROR; result.error_code = ERR_UNKNOWN;
      end
   end

endmodule

/* sv/ascii_motion_command_decoder.sv */
// Top level of the ASCII motion command decoder: byte intake, line store,
// scan sequencer and result register. Depends on amcd_pkg, amcd_line_ram, amcd_parser.
//
// Bytes enter one per transaction on req_; printable bytes are stored in a
// single-port-write RAM of LINE_MAX-1 characters. A CR or LF ending a
// non-empty line starts a scan that reads the RAM one character a cycle
// through its registered read port; the parser then classifies the line and
// the result is registered and offered on rsp_. req_tready stays low during
// the scan and while a result waits, and opens again the cycle after the
// result is taken. Empty line ends and non-printable bytes give no result;
// an overlong line gives a line-too-long error at once.
module ascii_motion_command_decoder #(
   parameter int LINE_MAX = 96
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [2:0] kind, [5:3] error_code,
                                    // [7:6] axis_index, [8] move_direction,
                                    // [40:9] step_count, [72:41] step_speed,
                                    // [79:73] zero
);
   import amcd_pkg::*;

   localparam int DEPTH = LINE_MAX - 1;
   localparam int LEN_W = $clog2(LINE_MAX);
   localparam int ADDR_W = $clog2(DEPTH);

   seq_state_type   st_ff, st_in;
   logic [LEN_W-1:0] len_ff, len_in, rpos_ff, rpos_in, cpos_ff, cpos_in;
   logic            cval_ff, cval_in;
   result_type      res_ff, res_in, pres;
   logic            acc, is_eol, is_prn, wr_en, start, char_en;
   logic [7:0]      rd_data;

   assign acc    = req_tvalid && req_tready;
   assign is_eol = (req_tdata == CH_CR) || (req_tdata == CH_LF);
   assign is_prn = (req_tdata >= CH_SPACE) && (req_tdata <= CH_TILDE);
   assign wr_en  = acc && is_prn && (len_ff < LEN_W'(DEPTH));
   assign req_tready = (st_ff == ST_COLLECT);

   amcd_line_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rpos_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign char_en = cval_ff;

   amcd_parser #(.LEN_W(LEN_W)) u_parser (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .char_en  (char_en),
      .pos      (cpos_ff),
      .chr      (rd_data),
      .line_len (len_ff),
      .result   (pres)
   );

   // Sequence intake, scan and result hand-off.
   always_comb begin
      st_in   = st_ff;
      len_in  = len_ff;
      rpos_in = rpos_ff;
      cpos_in = cpos_ff;
      cval_in = 1'b0;
      res_in  = res_ff;
      start   = 1'b0;
      unique case (st_ff)
         ST_COLLECT: begin
            start = 1'b1;
            rpos_in = '0;
            if (acc) begin
               if (is_eol) begin
                  if (len_ff != '0) begin
                     st_in = ST_SCAN;
                     rpos_in = LEN_W'(1);
                     cval_in = 1'b1;
                     cpos_in = '0;
                  end
               end else if (is_prn) begin
                  if (len_ff < LEN_W'(DEPTH)) begin
                     len_in = len_ff + LEN_W'(1);
                  end else begin
                     len_in = '0;
                     res_in = '0;
                     res_in.kind = KIND_ERROR;
                     res_in.error_code = ERR_TOO_LONG;
                     st_in = ST_OUT;
                  end
               end
            end
         end
         ST_SCAN: begin
            cpos_in = cpos_ff + LEN_W'(1);
            if (rpos_ff < len_ff) begin
               rpos_in = rpos_ff + LEN_W'(1);
               cval_in = 1'b1;
            end else begin
               st_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_in = pres;
            len_in = '0;
            st_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) st_in = ST_COLLECT;
         end
         default: st_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_COLLECT;
         len_ff  <= '0;
         cval_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         len_ff  <= len_in;
         cval_ff <= cval_in;
      end
      rpos_ff <= rpos_in;
      cpos_ff <= cpos_in;
      res_ff  <= res_in;
   end

   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata  = {7'd0, res_ff.step_speed, res_ff.step_count,
                        res_ff.move_direction, res_ff.axis_index,
                        res_ff.error_code, res_ff.kind};

endmodule

/* sv/amcd_checker.sv */
// Port-level checker for the ASCII motion command decoder, bound to the top.
// Depends on amcd_pkg and ascii_motion_command_decoder.
module amcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   import amcd_pkg::*;

   // Hold a result until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Accept no byte while a result waits.
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("intake open while result pending");

   // Kind stays in its legal range.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= KIND_ERROR)
      else $error("illegal result kind");

   // Error code only with an error kind.
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != KIND_ERROR |-> rsp_tdata[5:3] == ERR_NONE)
      else $error("error code on non-error result");

endmodule

bind ascii_motion_command_decoder amcd_checker u_amcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/tb_ascii_motion_command_decoder.sv */
// Testbench for the ASCII motion command decoder: streams bytes into req_, predicts each
// decoded command and checks rsp_ field by field. Depends on amcd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_ascii_motion_command_decoder;
   import amcd_pkg::*;

   localparam int LINE_MAX    = 96;
   localparam int DEPTH       = LINE_MAX - 1;
   localparam int WATCH_LIMIT = 20000;
   localparam int TARGET      = 950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;   // [2:0] kind, [5:3] error_code, [7:6] axis_index,
                             // [8] move_direction, [40:9] step_count, [72:41] step_speed

   ascii_motion_command_decoder #(.LINE_MAX(LINE_MAX)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   logic [7:0]  byte_queue[$];
   result_type  command_queue[$];
   int          error_count = 0;
   int          bytes_sent = 0;
   int          total_bytes = 1;
   int          idle_cycles = 0;
   bit          req_fired = 0;
   bit          stim_done = 0;

   // Shadow copy of the decoder's line buffer
   logic [7:0]  held_line[0:DEPTH-1];
   int          held_len = 0;

   function automatic logic [7:0] held_char(input int i);
      if (i < held_len) return held_line[i];
      return 8'h00;
   endfunction

   function automatic bit line_is(input string s);
      if (s.len() != held_len) return 0;
      for (int i = 0; i < s.len(); i++) if (held_char(i) != s[i]) return 0;
      return 1;
   endfunction

   function automatic bit line_starts(input string s);
      for (int i = 0; i < s.len(); i++) if (held_char(i) != s[i]) return 0;
      return 1;
   endfunction

   function automatic bit is_num(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic int past_spaces(input int p);
      while (held_char(p) == CH_SPACE) p++;
      return p;
   endfunction

   function automatic result_type error_of(input logic [ERR_W-1:0] code);
      result_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

   function automatic result_type parse_move();
      result_type  r;
      int          p;
      logic [7:0]  c;
      logic [31:0] acc;
      r = '0;
      p = past_spaces(5);
      c = held_char(p);
      if (c == 8'h00) return error_of(ERR_FORMAT);
      if (c == "X" || c == "x") r.axis_index = 2'd0;
      else if (c == "Y" || c == "y") r.axis_index = 2'd1;
      else if (c == "Z" || c == "z") r.axis_index = 2'd2;
      else return error_of(ERR_AXIS);
      p = past_spaces(p + 1);
      c = held_char(p);
      if (c != "0" && c != "1") return error_of(ERR_FORMAT);
      r.move_direction = c[0];
      p = past_spaces(p + 1);
      if (!is_num(held_char(p))) return error_of(ERR_FORMAT);
      acc = '0;
      while (is_num(held_char(p))) begin
         acc = acc * 10 + (held_char(p) - CH_ZERO);
         p++;
      end
      r.step_count = acc;
      p = past_spaces(p);
      if (!is_num(held_char(p))) return error_of(ERR_FORMAT);
      acc = '0;
      while (is_num(held_char(p))) begin
         acc = acc * 10 + (held_char(p) - CH_ZERO);
         p++;
      end
      r.step_speed = acc;
      p = past_spaces(p);
      if (held_char(p) != 8'h00) return error_of(ERR_FORMAT);
      r.kind = KIND_MOVE;
      return r;
   endfunction

   function automatic result_type decode_held();
      result_type r;
      logic [7:0] c;
      r = '0;
      if (line_is("PING") || line_is("STATUS")) r.kind = KIND_STATUS;
      else if (line_is("ARM SAFE")) r.kind = KIND_ARM;
      else if (line_is("HEARTBEAT SAFE")) r.kind = KIND_HEARTBEAT;
      else if (held_len == 6 && line_starts("STOP ")) begin
         c = held_char(5);
         r.kind = KIND_STOP_AXIS;
         if (c == "X") r.axis_index = 2'd0;
         else if (c == "Y") r.axis_index = 2'd1;
         else if (c == "Z") r.axis_index = 2'd2;
         else r = error_of(ERR_AXIS);
      end else if (line_is("HEARTBEAT UNSAFE") || line_is("STOP") || line_is("DISARM"))
         r.kind = KIND_DISARM;
      else if (line_starts("MOVE ")) r = parse_move();
      else r = error_of(ERR_UNKNOWN);
      return r;
   endfunction

   // Advance the shadow line by one accepted byte; queue a command if one results
   task automatic predict_byte(input logic [7:0] b);
      if (b == CH_CR || b == CH_LF) begin
         if (held_len > 0) begin
            command_queue.push_back(decode_held());
            held_len = 0;
         end
      end else if (b >= CH_SPACE && b <= CH_TILDE) begin
         if (held_len < DEPTH) begin
            held_line[held_len] = b;
            held_len++;
         end else begin
            held_len = 0;
            command_queue.push_back(error_of(ERR_TOO_LONG));
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Queue a line of text followed by a CR or LF
   task automatic push_line(input string s);
      for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
      byte_queue.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   function automatic string spaces(input int maxn);
      string s;
      s = "";
      repeat ($urandom_range(0, maxn)) s = {s, " "};
      return s;
   endfunction

   function automatic string rand_number();
      string s;
      case ($urandom_range(0, 3))
         0: s = $sformatf("%0d", $urandom_range(0, 9));
         1: s = $sformatf("%0d", $urandom_range(0, 99999));
         2: s = $sformatf("%0d", $urandom());
         default: begin
            // long run of digits to force the wrap
            s = "";
            repeat ($urandom_range(10, 20)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
         end
      endcase
      return s;
   endfunction

   function automatic string rand_move();
      string axes;
      axes = "XYZxyz";
      return {"MOVE ", spaces(2), axes.substr($urandom_range(0, 5), 0), spaces(2),
              $urandom_range(0, 1) ? "1" : "0", spaces(2), rand_number(), " ", spaces(2),
              rand_number(), spaces(2)};
   endfunction

   function automatic string rand_line();
      string s;
      string names[10];
      names = '{"PING", "STATUS", "ARM SAFE", "HEARTBEAT SAFE", "HEARTBEAT UNSAFE",
                "STOP", "DISARM", "STOP X", "STOP Y", "STOP Z"};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s = rand_move();
         4, 5, 6: s = names[$urandom_range(0, 9)];
         7: s = {"STOP ", string'(8'($urandom_range(32, 126)))};
         default: begin
            s = ($urandom_range(0, 1)) ? rand_move() : names[$urandom_range(0, 9)];
         end
      endcase
      // corrupt some lines with one random printable character
      if ($urandom_range(0, 3) == 0 && s.len() > 0)
         s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(32, 126));
      return s;
   endfunction

   // Stimulus: directed lines first, then random lines and noise
   initial begin
      string long_line;
      push_line("PING");
      push_line("STATUS");
      push_line("ARM SAFE");
      push_line("HEARTBEAT SAFE");
      push_line("HEARTBEAT UNSAFE");
      push_line("STOP");
      push_line("DISARM");
      push_line("STOP X");
      push_line("STOP Z");
      push_line("STOP x");
      push_line("STOP ");
      push_line("STOP XY");
      push_line("MOVE ");
      push_line("MOVE y1 0 4294967295");
      push_line("MOVE  Z 0 99999999999 12345678901  ");
      push_line("MOVE Q 1 5 5");
      push_line("MOVE X 2 5 5");
      push_line("MOVE X 1 5");
      push_line("MOVE X 1 5 5 A");
      push_line("PINGX");
      byte_queue.push_back(CH_LF);         // empty line end
      byte_queue.push_back(8'h00);
      byte_queue.push_back(8'hFF);
      byte_queue.push_back(8'h7F);
      long_line = "";
      repeat (DEPTH + 1) long_line = {long_line, "A"};
      push_line(long_line);
      while (byte_queue.size() < TARGET) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom()));
         else
            push_line(rand_line());
      end
      total_bytes = byte_queue.size();
      stim_done = 1;
   end

   // Sequence reset, then wait for the drain and give the verdict
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && byte_queue.size() == 0 && command_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && command_queue.size() == 0)
         $display("tb_ascii_motion_command_decoder: PASS");
      else
         $display("tb_ascii_motion_command_decoder: FAIL");
      $finish;
   end

   // Idle percentages by phase of the run
   function automatic int sender_idle_pct();
      case (bytes_sent * 4 / total_bytes)
         0: return 0;
         1: return 58;
         2: return 0;
         default: return 7;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (bytes_sent * 4 / total_bytes)
         0, 1: return 0;
         2: return 58;
         default: return 7;
      endcase
   endfunction

   // Drive the request side and rsp_tready at the falling edge
   always @(negedge clock) begin
      if (reset || !stim_done) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         req_tvalid <= 1'b1;
      end else if (byte_queue.size() > 0 && $urandom_range(1, 100) > sender_idle_pct()) begin
         req_tvalid <= 1'b1;
         req_tdata  <= byte_queue[0];
      end else begin
         req_tvalid <= 1'b0;
      end
      rsp_tready <= !reset && ($urandom_range(1, 100) > receiver_stall_pct());
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      result_type want;
      req_fired = 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fired = 1;
            predict_byte(req_tdata);
            void'(byte_queue.pop_front());
            bytes_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (command_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 32'h0);
            end else begin
               want = command_queue.pop_front();
               if (rsp_tdata[2:0] != want.kind)
                  report_mismatch("kind", rsp_tdata[2:0], want.kind);
               if (rsp_tdata[5:3] != want.error_code)
                  report_mismatch("error_code", rsp_tdata[5:3], want.error_code);
               if (rsp_tdata[7:6] != want.axis_index)
                  report_mismatch("axis_index", rsp_tdata[7:6], want.axis_index);
               if (rsp_tdata[8] != want.move_direction)
                  report_mismatch("move_direction", rsp_tdata[8], want.move_direction);
               if (rsp_tdata[40:9] != want.step_count)
                  report_mismatch("step_count", rsp_tdata[40:9], want.step_count);
               if (rsp_tdata[72:41] != want.step_speed)
                  report_mismatch("step_speed", rsp_tdata[72:41], want.step_speed);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("tb_ascii_motion_command_decoder: FAIL");
         $finish;
      end
   end

endmodule

/* files.f */
sv/amcd_pkg.sv
sv/amcd_line_ram.sv
sv/amcd_parser.sv
sv/ascii_motion_command_decoder.sv
sv/amcd_checker.sv
bench/tb_ascii_motion_command_decoder.sv
